// ===== src/sbph_pkg.sv =====
// shared types and constants for the spectrum bar peak hold and decay unit
// no dependencies

package sbph_pkg;

  localparam int unsigned BinW     = 24;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned StoreW   = 15;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned GainW    = 16;
  localparam int unsigned MarginW  = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegLevelGain  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMarginBars = 1'b1;

  localparam logic [GainW-1:0]   GainReset   = 16'd1024;
  localparam logic [MarginW-1:0] MarginReset = 4'd4;

  typedef struct packed {
    logic vld;
    logic last;
    logic direct;
  } dec_ctl_t;

endpackage

// ===== src/spectrum_bar_peak_hold_decay_unit.sv =====
// Spectrum bar graph with peak hold and decay.
// Input channel: one signed bin per request (bin_value_i, frame_start_i), valid/ready.
// Output channel: one bar per request (bar_index_o, bar_level_o, last_of_run_o),
// valid/ready, registered. Config: cfg_we_i writes level_gain (index 0) or
// margin_bars (index 1); the user must write only while the block is idle, since
// the block itself does not enforce it. Bins are taken only in the idle state;
// the bin that closes a column starts a burst of BARS/COLUMNS bars. The column
// sum is multiplied by the gain in ST_MUL and saturated in ST_SCALE, then one bar
// is read from the level memory per cycle while the receiver does not stall,
// compared in one stage and runs through a three-stage decay pipeline.
// The single read port of the level memory sets the one-bar-per-cycle rate.
// After reset the level and hold counter memories are swept to zero, one entry
// per cycle; no bin is taken meanwhile.
// When the receiver stalls, the whole bar pipeline holds; bins already waiting
// are taken only once the burst has left the pipeline.
// depends on sbph_pkg, sbph_front, sbph_decay

module spectrum_bar_peak_hold_decay_unit #(
  parameter int unsigned BARS        = 256,
  parameter int unsigned COLUMNS     = 32,
  parameter int unsigned HOLD_FRAMES = 500
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sbph_pkg::BinW-1:0]     bin_value_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sbph_pkg::IdxW-1:0]            bar_index_o,
  output logic signed [sbph_pkg::LevelW-1:0]   bar_level_o,
  output logic                                 last_of_run_o,
  input  logic                                 cfg_we_i,
  input  logic [sbph_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sbph_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned ColW    = BARS / COLUMNS;
  localparam int unsigned PosW    = $clog2(BARS);
  localparam int unsigned OffW    = (ColW > 1) ? $clog2(ColW) : 1;
  localparam int unsigned SumW    = sbph_pkg::BinW + $clog2(ColW);
  localparam int unsigned GainW   = sbph_pkg::GainW;
  localparam int unsigned ProdW   = SumW + GainW + 1;
  localparam int unsigned ColIdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CntW    = $clog2(HOLD_FRAMES + 1);
  localparam int unsigned FacW    = $clog2(HOLD_FRAMES + 2);
  localparam int unsigned MarW    = OffW + 5;
  localparam int unsigned StoreW  = sbph_pkg::StoreW;
  localparam int unsigned LevelW  = sbph_pkg::LevelW;

  localparam logic signed [ProdW-1:0] SatHi = ProdW'(32767);
  localparam logic signed [ProdW-1:0] SatLo = -ProdW'(32768);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                   state_q;
  logic [PosW-1:0]          clr_q;
  logic [OffW-1:0]          idx_q;
  logic [PosW-1:0]          addr_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [LevelW-1:0] scaled_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [ProdW-1:0]  prod_sh;
  logic signed [LevelW-1:0] scaled_d;

  logic [GainW-1:0]             gain_q;
  logic [sbph_pkg::MarginW-1:0] margin_q;

  logic                     accept, col_end;
  logic signed [SumW-1:0]   fin_sum;
  logic [ColIdxW-1:0]       fin_col;
  logic [PosW-1:0]          fin_base;

  logic                     en, issue, issue_margin, issue_last;
  logic                     b_vld_q, b_last_q, b_margin_q;
  logic [PosW-1:0]          b_addr_q;
  logic [StoreW-1:0]        prev_rd_q;
  logic                     rise;
  logic [CntW-1:0]          cnt_after, hold_wr_val, hold_rd_q;
  logic [FacW-1:0]          factor;

  sbph_pkg::dec_ctl_t       dec_in, dec_out;
  logic [PosW-1:0]          dec_addr;
  logic [StoreW-1:0]        dec_level, direct_lvl;
  logic                     dec_busy;

  logic [StoreW-1:0]        lvl_mem [BARS];
  logic [CntW-1:0]          hold_mem [COLUMNS];
  logic                     lvl_we, hold_we;
  logic [PosW-1:0]          lvl_wa;
  logic [StoreW-1:0]        lvl_wd;
  logic [ColIdxW-1:0]       hold_wa;
  logic [CntW-1:0]          hold_wd;

  logic                     out_valid_q, last_q;
  logic [sbph_pkg::IdxW-1:0] index_q;
  logic [StoreW-1:0]        level_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  sbph_front #(
    .BARS    (BARS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .bin_i         (bin_value_i),
    .frame_start_i (frame_start_i),
    .col_end_o     (col_end),
    .fin_sum_o     (fin_sum),
    .fin_col_o     (fin_col),
    .fin_base_o    (fin_base)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= sbph_pkg::GainReset;
      margin_q <= sbph_pkg::MarginReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sbph_pkg::RegLevelGain:  gain_q   <= cfg_data_i[GainW-1:0];
        sbph_pkg::RegMarginBars: margin_q <= cfg_data_i[sbph_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  // column scaling
  assign prod_d  = ProdW'(fin_sum) * ProdW'($signed({1'b0, gain_q}));
  assign prod_sh = prod_q >>> GainW;

  always_comb begin
    if (prod_sh > SatHi) begin
      scaled_d = LevelW'(SatHi);
    end else if (prod_sh < SatLo) begin
      scaled_d = LevelW'(SatLo);
    end else begin
      scaled_d = LevelW'(prod_sh);
    end
  end

  assign en           = !out_valid_q || out_ready_i;
  assign issue        = (state_q == ST_RUN) && en;
  assign issue_last   = idx_q == OffW'(ColW - 1);
  assign issue_margin = (MarW'(idx_q) + MarW'(margin_q)) >= MarW'(ColW);

  // bar compare stage
  assign rise       = !b_margin_q && (scaled_q > $signed({1'b0, prev_rd_q}));
  assign direct_lvl = b_margin_q ? '0 : scaled_q[StoreW-1:0];
  assign factor     = FacW'(HOLD_FRAMES + 1) - FacW'(cnt_q);
  assign cnt_after  = rise ? CntW'(HOLD_FRAMES) : cnt_q;
  assign hold_wr_val = (cnt_after != '0) ? cnt_after - CntW'(1) : '0;

  assign dec_in.vld    = b_vld_q;
  assign dec_in.last   = b_last_q;
  assign dec_in.direct = b_margin_q || rise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      idx_q    <= '0;
      addr_q   <= '0;
      cnt_q    <= '0;
      scaled_q <= '0;
      prod_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + PosW'(1);
          if (clr_q == PosW'(BARS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && col_end) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          scaled_q <= scaled_d;
          cnt_q    <= hold_rd_q;
          addr_q   <= fin_base;
          idx_q    <= '0;
          state_q  <= ST_RUN;
        end
        ST_RUN: begin
          if (en) begin
            addr_q <= addr_q + PosW'(1);
            idx_q  <= idx_q + OffW'(1);
            if (issue_last) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!b_vld_q && !dec_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // later bars of the column see a counter set by an earlier one
      if (en && b_vld_q && rise) begin
        cnt_q <= CntW'(HOLD_FRAMES);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_last_q   <= issue_last;
      b_margin_q <= issue_margin;
      b_addr_q   <= addr_q;
    end
  end

  sbph_decay #(
    .HOLD_FRAMES (HOLD_FRAMES),
    .ADDR_W      (PosW)
  ) u_decay (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctl_i        (dec_in),
    .addr_i       (b_addr_q),
    .prev_i       (prev_rd_q),
    .direct_lvl_i (direct_lvl),
    .factor_i     (factor),
    .ctl_o        (dec_out),
    .addr_o       (dec_addr),
    .level_o      (dec_level),
    .busy_o       (dec_busy)
  );

  // level memory
  assign lvl_we = (state_q == ST_CLEAR) || (en && dec_out.vld);
  assign lvl_wa = (state_q == ST_CLEAR) ? clr_q : dec_addr;
  assign lvl_wd = (state_q == ST_CLEAR) ? '0 : dec_level;

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    if (issue) begin
      prev_rd_q <= lvl_mem[addr_q];
    end
  end

  // hold counter memory
  assign hold_we = ((state_q == ST_CLEAR) && ((PosW+1)'(clr_q) < (PosW+1)'(COLUMNS)))
                 || (en && b_vld_q && b_last_q);
  assign hold_wa = (state_q == ST_CLEAR) ? clr_q[ColIdxW-1:0] : fin_col;
  assign hold_wd = (state_q == ST_CLEAR) ? '0 : hold_wr_val;

  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_mem[hold_wa] <= hold_wd;
    end
    if (state_q == ST_MUL) begin
      hold_rd_q <= hold_mem[fin_col];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dec_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      index_q <= sbph_pkg::IdxW'(dec_addr);
      level_q <= dec_level;
      last_q  <= dec_out.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bar_index_o   = index_q;
  assign bar_level_o   = LevelW'(level_q);
  assign last_of_run_o = last_q;

endmodule

// ===== src/sbph_front.sv =====
// input side: bin position tracking and running column sum
// depends on sbph_pkg

module sbph_front #(
  parameter int unsigned BARS    = 256,
  parameter int unsigned COLUMNS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  logic signed [sbph_pkg::BinW-1:0]        bin_i,
  input  logic                                    frame_start_i,
  output logic                                    col_end_o,
  output logic signed [sbph_pkg::BinW+$clog2(BARS/COLUMNS)-1:0] fin_sum_o,
  output logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0]      fin_col_o,
  output logic [$clog2(BARS)-1:0]                 fin_base_o
);

  localparam int unsigned ColW    = BARS / COLUMNS;
  localparam int unsigned PosW    = $clog2(BARS);
  localparam int unsigned OffW    = (ColW > 1) ? $clog2(ColW) : 1;
  localparam int unsigned SumW    = sbph_pkg::BinW + $clog2(ColW);
  localparam int unsigned ColIdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [PosW-1:0]        pos_q, pos_cur;
  logic [OffW-1:0]        off_q, off_cur;
  logic [PosW-1:0]        col_q, col_cur;
  logic signed [SumW-1:0] sum_q, sum_cur, sum_add;
  logic                   in_range, last_off;

  logic signed [SumW-1:0] fin_sum_q;
  logic [ColIdxW-1:0]     fin_col_q;
  logic [PosW-1:0]        fin_base_q;

  assign pos_cur  = frame_start_i ? '0 : pos_q;
  assign off_cur  = frame_start_i ? '0 : off_q;
  assign col_cur  = frame_start_i ? '0 : col_q;
  assign sum_cur  = frame_start_i ? '0 : sum_q;
  assign sum_add  = sum_cur + SumW'(bin_i);
  assign in_range = (PosW+1)'(col_cur) < (PosW+1)'(COLUMNS);
  assign last_off = off_cur == OffW'(ColW - 1);
  assign col_end_o = in_range && last_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      off_q <= '0;
      col_q <= '0;
      sum_q <= '0;
    end else if (accept_i) begin
      if (pos_cur == PosW'(BARS - 1)) begin
        pos_q <= '0;
        off_q <= '0;
        col_q <= '0;
      end else begin
        pos_q <= pos_cur + PosW'(1);
        if (last_off) begin
          off_q <= '0;
          col_q <= col_cur + PosW'(1);
        end else begin
          off_q <= off_cur + OffW'(1);
          col_q <= col_cur;
        end
      end
      if (col_end_o) begin
        sum_q <= '0;
      end else if (in_range) begin
        sum_q <= sum_add;
      end else begin
        sum_q <= sum_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && col_end_o) begin
      fin_sum_q  <= sum_add;
      fin_col_q  <= col_cur[ColIdxW-1:0];
      fin_base_q <= pos_cur - PosW'(ColW - 1);
    end
  end

  assign fin_sum_o  = fin_sum_q;
  assign fin_col_o  = fin_col_q;
  assign fin_base_o = fin_base_q;

endmodule

// ===== src/sbph_decay.sv =====
// decay pipeline: prev*factor, divide by the hold length via reciprocal and correction
// depends on sbph_pkg

module sbph_decay #(
  parameter int unsigned HOLD_FRAMES = 500,
  parameter int unsigned ADDR_W      = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  sbph_pkg::dec_ctl_t                  ctl_i,
  input  logic [ADDR_W-1:0]                   addr_i,
  input  logic [sbph_pkg::StoreW-1:0]         prev_i,
  input  logic [sbph_pkg::StoreW-1:0]         direct_lvl_i,
  input  logic [$clog2(HOLD_FRAMES+2)-1:0]    factor_i,
  output sbph_pkg::dec_ctl_t                  ctl_o,
  output logic [ADDR_W-1:0]                   addr_o,
  output logic [sbph_pkg::StoreW-1:0]         level_o,
  output logic                                busy_o
);

  localparam int unsigned StoreW = sbph_pkg::StoreW;
  localparam int unsigned FacW   = $clog2(HOLD_FRAMES + 2);
  localparam int unsigned ProdW  = StoreW + FacW;
  localparam int unsigned QuotW  = StoreW + 1;
  localparam int unsigned Recip  = (2 ** ProdW) / HOLD_FRAMES;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned RpW    = ProdW + RecipW;

  sbph_pkg::dec_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [ADDR_W-1:0]  s1_addr_q, s2_addr_q, s3_addr_q;
  logic [StoreW-1:0]  s1_prev_q, s2_prev_q, s3_prev_q;
  logic [StoreW-1:0]  s1_dir_q, s2_dir_q, s3_dir_q;
  logic [ProdW-1:0]   s1_p_q, s2_p_q, s3_p_q;
  logic [QuotW-1:0]   s2_q_q, s3_q_q;
  logic [ProdW-1:0]   s3_qh_q;

  logic [RpW-1:0]     recip_prod;
  logic [ProdW-1:0]   rem;
  logic [QuotW-1:0]   quot;

  assign recip_prod = RpW'(s1_p_q) * RpW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (en_i) begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_addr_q <= addr_i;
      s1_prev_q <= prev_i;
      s1_dir_q  <= direct_lvl_i;
      s1_p_q    <= ProdW'(prev_i) * ProdW'(factor_i);

      s2_addr_q <= s1_addr_q;
      s2_prev_q <= s1_prev_q;
      s2_dir_q  <= s1_dir_q;
      s2_p_q    <= s1_p_q;
      s2_q_q    <= QuotW'(recip_prod >> ProdW);

      s3_addr_q <= s2_addr_q;
      s3_prev_q <= s2_prev_q;
      s3_dir_q  <= s2_dir_q;
      s3_p_q    <= s2_p_q;
      s3_q_q    <= s2_q_q;
      s3_qh_q   <= ProdW'(s2_q_q) * ProdW'(HOLD_FRAMES);
    end
  end

  // reciprocal estimate is low by at most one
  assign rem  = s3_p_q - s3_qh_q;
  assign quot = s3_q_q + QuotW'(rem >= ProdW'(HOLD_FRAMES));

  always_comb begin
    if (s3_ctl_q.direct) begin
      level_o = s3_dir_q;
    end else if (quot >= QuotW'(s3_prev_q)) begin
      level_o = '0;
    end else begin
      level_o = StoreW'(QuotW'(s3_prev_q) - quot);
    end
  end

  assign ctl_o  = s3_ctl_q;
  assign addr_o = s3_addr_q;
  assign busy_o = s1_ctl_q.vld || s2_ctl_q.vld || s3_ctl_q.vld;

endmodule

// ===== src/sbph_checker.sv =====
// port-level checks for the spectrum bar peak hold and decay unit
// depends on sbph_pkg; bound to spectrum_bar_peak_hold_decay_unit

module sbph_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [sbph_pkg::IdxW-1:0]          bar_index_o,
  input logic signed [sbph_pkg::LevelW-1:0] bar_level_o,
  input logic                               last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bar_index_o)
      && $stable(bar_level_o) && $stable(last_of_run_o))
    else $error("output request changed while stalled");

  a_level_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bar_level_o[sbph_pkg::LevelW-1])
    else $error("negative bar level");

  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> !in_ready_o)
    else $error("input taken in the middle of a bar burst");

endmodule

bind spectrum_bar_peak_hold_decay_unit sbph_checker u_sbph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .bar_index_o   (bar_index_o),
  .bar_level_o   (bar_level_o),
  .last_of_run_o (last_of_run_o)
);
